@@ hdl/first_fit_heap_allocator_unit_defines.svh @@
// ============================================================================
// First-fit heap allocator assertion macros
// Shared property forms for the interface checker of the allocator.
// ============================================================================
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, quiet while reset is held.
`define FHA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define FHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/fha_pkg.sv @@
// ============================================================================
// First-fit heap allocator package
// Sizes, operation and status codes, and the block table entry type.
// ============================================================================
`timescale 1ns / 1ps

package fha_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 8;
    localparam int MAX_BLOCKS   = 64;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [15:0] INIT_START = 16'(HEADER_BYTES);
    localparam logic [15:0] INIT_SIZE  = 16'(HEAP_BYTES - HEADER_BYTES);

    // Operation codes.
    localparam logic [1:0] FN_INIT    = 2'd0;
    localparam logic [1:0] FN_ALLOC   = 2'd1;
    localparam logic [1:0] FN_FREE    = 2'd2;
    localparam logic [1:0] FN_REALLOC = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_NOINIT  = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    // One block of the address-ordered table.
    typedef struct packed {
        logic [15:0] start;
        logic [15:0] size;
        logic        free;
    } entry_t;

    // Write port of the block table.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } tbl_wr_t;

endpackage

@@ hdl/first_fit_heap_allocator_unit.sv @@
// ============================================================================
// First-fit heap allocator
// Init, alloc, free and realloc over an address-ordered table of heap blocks.
// ============================================================================
// One request is in flight at a time. Every table walk goes through the
// block memory's one registered read port, one entry at a time (address,
// then registered data). Init and requests before init need no walk; alloc
// walks the table for a first fit and moves later entries up when a block is
// split, free searches for the block and then runs a merge pass, and a
// realloc that moves does both.
`timescale 1ns / 1ps

module first_fit_heap_allocator_unit
    import fha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] request_size, [31:16] block_address
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] address, [31:16] copy_length
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    tbl_wr_t          wr;
    logic [15:0]      alu_a;
    logic [15:0]      alu_b;
    logic [16:0]      alu_sum;
    logic [17:0]      alu_diff;
    logic [15:0]      res_addr;
    logic [15:0]      res_copy;

    fha_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser),
        .in_req     (s_tdata[15:0]),
        .in_addr    (s_tdata[31:16]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_addr   (res_addr),
        .out_status (m_tuser),
        .out_copy   (res_copy),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr         (wr),
        .alu_a      (alu_a),
        .alu_b      (alu_b),
        .alu_sum    (alu_sum),
        .alu_diff   (alu_diff)
    );

    fha_table u_table (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fha_alu u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .sum  (alu_sum),
        .diff (alu_diff)
    );

    // Result transaction payload.
    assign m_tdata = {res_copy, res_addr};

endmodule

@@ hdl/fha_alu.sv @@
// ============================================================================
// Shared header adder
// Adds or subtracts two sizes together with one block header.
// ============================================================================
`timescale 1ns / 1ps

module fha_alu
    import fha_pkg::*;
(
    input  logic [15:0] op_a,
    input  logic [15:0] op_b,
    output logic [16:0] sum,   // op_a + op_b + header
    output logic [17:0] diff   // op_a - op_b - header, two's complement
);

    // Both results share the same operands chosen by the sequencer.
    assign sum  = {1'b0, op_a} + {1'b0, op_b} + 17'(HEADER_BYTES);
    assign diff = {2'b00, op_a} - {2'b00, op_b} - 18'(HEADER_BYTES);

endmodule

@@ hdl/fha_table.sv @@
// ============================================================================
// Block table memory
// One write port and one registered read port over the block entries.
// ============================================================================
`timescale 1ns / 1ps

module fha_table
    import fha_pkg::*;
(
    input  logic             aclk,
    input  tbl_wr_t          wr,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [MAX_BLOCKS];

    // Read before write: a read of the address being written returns the old
    // entry. Read data is registered for the next cycle.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/fha_seq.sv @@
// ============================================================================
// Allocator sequencer
// Walks the block table one entry at a time for find, alloc, shift and merge.
// ============================================================================
`timescale 1ns / 1ps

module fha_seq
    import fha_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_func,
    input  logic [15:0]      in_req,
    input  logic [15:0]      in_addr,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [15:0]      out_addr,
    output logic [1:0]       out_status,
    output logic [15:0]      out_copy,
    output logic [IDX_W-1:0] rd_addr,
    input  entry_t           rd_data,
    output tbl_wr_t          wr,
    output logic [15:0]      alu_a,
    output logic [15:0]      alu_b,
    input  logic [16:0]      alu_sum,
    input  logic [17:0]      alu_diff
);

    typedef enum logic [3:0] {
        S_IDLE, S_FIND_RD, S_FIND_CHK, S_F_MARK, S_A_RD, S_A_CHK, S_SH_RD,
        S_SH_WR, S_SPLIT, S_A_FIN, S_C_RD0, S_C_LD, S_C_RD, S_C_CHK
    } state_t;

    typedef enum logic [1:0] {
        MD_ALLOC, MD_FREE, MD_REALLOC, MD_MOVE_FREE
    } mode_t;

    state_t           state_reg;
    mode_t            mode_reg;
    logic             init_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] k_reg;
    logic [IDX_W-1:0] w_reg;
    entry_t           acc_reg;
    logic [15:0]      split_size_reg;
    logic [15:0]      old_size_reg;
    logic [15:0]      req_reg;
    logic [15:0]      addr_reg;
    logic             out_valid_reg;
    logic [15:0]      out_addr_reg;
    logic [1:0]       out_status_reg;
    logic [15:0]      out_copy_reg;

    logic accept;
    logic fits;
    logic split_ok;
    logic merge;
    logic [CNT_W-1:0] j_prev;

    assign in_ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_addr   = out_addr_reg;
    assign out_status = out_status_reg;
    assign out_copy   = out_copy_reg;

    // Decisions taken on the entry that was just read.
    assign fits     = rd_data.free && (rd_data.size >= req_reg);
    assign split_ok = !alu_diff[17] && (alu_diff != '0) &&
                      (count_reg < CNT_W'(MAX_BLOCKS));
    assign merge    = acc_reg.free && rd_data.free;
    assign j_prev   = j_reg - CNT_W'(1);

    // Table addressing, write data and shared adder operands.
    always_comb begin
        wr      = '0;
        rd_addr = idx_reg[IDX_W-1:0];
        alu_a   = rd_data.size;
        alu_b   = req_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && in_func == FN_INIT) begin
                    wr.en   = 1'b1;
                    wr.addr = '0;
                    wr.data = '{start: INIT_START, size: INIT_SIZE, free: 1'b1};
                end
            end
            S_A_CHK: begin
                if (fits && !split_ok) begin
                    wr.en   = 1'b1;
                    wr.addr = idx_reg[IDX_W-1:0];
                    wr.data = '{start: rd_data.start, size: rd_data.size, free: 1'b0};
                end
            end
            S_SH_RD: begin
                rd_addr = j_prev[IDX_W-1:0];
                alu_a   = acc_reg.start;
                if (j_reg == k_reg + CNT_W'(1)) begin
                    wr.en   = 1'b1;
                    wr.addr = j_reg[IDX_W-1:0];
                    wr.data = '{start: alu_sum[15:0], size: split_size_reg, free: 1'b1};
                end
            end
            S_SH_WR: begin
                wr.en   = 1'b1;
                wr.addr = j_reg[IDX_W-1:0];
                wr.data = rd_data;
            end
            S_SPLIT: begin
                wr.en   = 1'b1;
                wr.addr = k_reg[IDX_W-1:0];
                wr.data = '{start: acc_reg.start, size: req_reg, free: 1'b0};
            end
            S_F_MARK: begin
                wr.en   = 1'b1;
                wr.addr = k_reg[IDX_W-1:0];
                wr.data = '{start: acc_reg.start, size: acc_reg.size, free: 1'b1};
            end
            S_C_RD0: begin
                rd_addr = '0;
            end
            S_C_RD: begin
                if (idx_reg == count_reg) begin
                    wr.en   = 1'b1;
                    wr.addr = w_reg;
                    wr.data = acc_reg;
                end
            end
            S_C_CHK: begin
                alu_a = acc_reg.size;
                alu_b = rd_data.size;
                if (!merge) begin
                    wr.en   = 1'b1;
                    wr.addr = w_reg;
                    wr.data = acc_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer state, table bookkeeping and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            mode_reg      <= MD_ALLOC;
            init_reg      <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        req_reg        <= in_req;
                        addr_reg       <= in_addr;
                        out_addr_reg   <= '0;
                        out_status_reg <= ST_OK;
                        out_copy_reg   <= '0;
                        idx_reg        <= '0;
                        if (in_func == FN_INIT) begin
                            count_reg     <= CNT_W'(1);
                            init_reg      <= 1'b1;
                            out_valid_reg <= 1'b1;
                        end else if (!init_reg) begin
                            out_status_reg <= ST_NOINIT;
                            out_valid_reg  <= 1'b1;
                        end else if (in_func == FN_ALLOC ||
                                     (in_func == FN_REALLOC && in_addr == '0)) begin
                            mode_reg  <= MD_ALLOC;
                            state_reg <= S_A_RD;
                        end else if (in_func == FN_FREE || in_req == '0) begin
                            if (in_addr == '0) begin
                                out_valid_reg <= 1'b1;
                            end else begin
                                mode_reg  <= MD_FREE;
                                state_reg <= S_FIND_RD;
                            end
                        end else begin
                            mode_reg  <= MD_REALLOC;
                            state_reg <= S_FIND_RD;
                        end
                    end
                end
                // Search for the allocated block at the given payload offset.
                S_FIND_RD: begin
                    if (idx_reg == count_reg) begin
                        out_status_reg <= ST_UNKNOWN;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end else begin
                        state_reg <= S_FIND_CHK;
                    end
                end
                S_FIND_CHK: begin
                    if (rd_data.start == addr_reg && !rd_data.free) begin
                        acc_reg <= rd_data;
                        k_reg   <= idx_reg;
                        if (mode_reg == MD_REALLOC) begin
                            if (rd_data.size >= req_reg) begin
                                out_addr_reg  <= addr_reg;
                                out_valid_reg <= 1'b1;
                                state_reg     <= S_IDLE;
                            end else begin
                                old_size_reg <= rd_data.size;
                                idx_reg      <= '0;
                                state_reg    <= S_A_RD;
                            end
                        end else begin
                            state_reg <= S_F_MARK;
                        end
                    end else begin
                        idx_reg   <= idx_reg + CNT_W'(1);
                        state_reg <= S_FIND_RD;
                    end
                end
                S_F_MARK: begin
                    state_reg <= S_C_RD0;
                end
                // First-fit search.
                S_A_RD: begin
                    if (idx_reg == count_reg) begin
                        out_status_reg <= ST_NOFIT;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end else begin
                        state_reg <= S_A_CHK;
                    end
                end
                S_A_CHK: begin
                    if (fits) begin
                        acc_reg        <= rd_data;
                        k_reg          <= idx_reg;
                        split_size_reg <= alu_diff[15:0];
                        j_reg          <= count_reg;
                        state_reg      <= split_ok ? S_SH_RD : S_A_FIN;
                    end else begin
                        idx_reg   <= idx_reg + CNT_W'(1);
                        state_reg <= S_A_RD;
                    end
                end
                // Open a slot after the chosen block, moving the tail up by one.
                S_SH_RD: begin
                    state_reg <= (j_reg == k_reg + CNT_W'(1)) ? S_SPLIT : S_SH_WR;
                end
                S_SH_WR: begin
                    j_reg     <= j_prev;
                    state_reg <= S_SH_RD;
                end
                S_SPLIT: begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= S_A_FIN;
                end
                S_A_FIN: begin
                    out_addr_reg <= acc_reg.start;
                    if (mode_reg == MD_REALLOC) begin
                        out_copy_reg <= old_size_reg;
                        mode_reg     <= MD_MOVE_FREE;
                        idx_reg      <= '0;
                        state_reg    <= S_FIND_RD;
                    end else begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                // Compaction pass: merge every run of free blocks.
                S_C_RD0: begin
                    state_reg <= S_C_LD;
                end
                S_C_LD: begin
                    acc_reg   <= rd_data;
                    w_reg     <= '0;
                    idx_reg   <= CNT_W'(1);
                    state_reg <= S_C_RD;
                end
                S_C_RD: begin
                    if (idx_reg == count_reg) begin
                        count_reg     <= {1'b0, w_reg} + CNT_W'(1);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end else begin
                        state_reg <= S_C_CHK;
                    end
                end
                S_C_CHK: begin
                    if (merge) begin
                        acc_reg.size <= alu_sum[15:0];
                    end else begin
                        acc_reg <= rd_data;
                        w_reg   <= w_reg + IDX_W'(1);
                    end
                    idx_reg   <= idx_reg + CNT_W'(1);
                    state_reg <= S_C_RD;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/fha_checker.sv @@
// ============================================================================
// Allocator interface checker
// Port-level properties of the allocator, attached by a bind statement.
// ============================================================================
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_unit_defines.svh"

module fha_checker
    import fha_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A failed request never returns an address.
    `FHA_ASSERT_NOW(a_err_no_addr, m_tvalid && m_tuser != ST_OK, m_tdata[15:0] == 16'd0, "address on failed request")

    // A copy length only comes with a successful move.
    `FHA_ASSERT_NOW(a_copy_ok, m_tvalid && m_tdata[31:16] != 16'd0, m_tuser == ST_OK && m_tdata[15:0] != 16'd0, "copy length without a move")

    // The block is busy right after it takes a request.
    `FHA_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "ready right after accept")

    // No new request while a result still waits.
    `FHA_ASSERT_NOW(a_one_out, m_tvalid, !s_tready, "ready while result pending")

    // A stalled result stays offered.
    `FHA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

endmodule

bind first_fit_heap_allocator_unit fha_checker u_fha_checker (.*);

@@ test/first_fit_heap_allocator_unit_checker.sv @@
// ============================================================================
// First-fit heap allocator checker
// Watches both stream channels and keeps its own copy of the block table.
// It predicts each result and compares it field by field with the block.
// ============================================================================
`timescale 1ns / 1ps

module first_fit_heap_allocator_unit_checker
    import fha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          mismatch_count,
    output int          pending_count
);

    typedef struct packed {
        logic [15:0] address;
        logic [1:0]  status;
        logic [15:0] copy_length;
    } alloc_result_t;

    // Shadow copy of the block table.
    int            shadow_start [MAX_BLOCKS];
    int            shadow_size  [MAX_BLOCKS];
    bit            shadow_free  [MAX_BLOCKS];
    int            shadow_count;
    bit            shadow_ready;
    alloc_result_t expected_results[$];

    // Index of the allocated block whose payload starts at addr, or -1.
    function automatic int lookup_used(int addr);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_start[i] == addr && !shadow_free[i])
                return i;
        return -1;
    endfunction

    // First fit, with a split when the remainder can hold a header.
    function automatic logic [1:0] take_first_fit(int req, output logic [15:0] addr);
        addr = '0;
        for (int i = 0; i < shadow_count; i++) begin
            if (!shadow_free[i] || shadow_size[i] < req)
                continue;
            if (shadow_size[i] > req + HEADER_BYTES && shadow_count < MAX_BLOCKS) begin
                for (int j = shadow_count; j > i + 1; j--) begin
                    shadow_start[j] = shadow_start[j-1];
                    shadow_size[j]  = shadow_size[j-1];
                    shadow_free[j]  = shadow_free[j-1];
                end
                shadow_start[i+1] = shadow_start[i] + req + HEADER_BYTES;
                shadow_size[i+1]  = shadow_size[i] - req - HEADER_BYTES;
                shadow_free[i+1]  = 1'b1;
                shadow_size[i]    = req;
                shadow_count++;
            end
            shadow_free[i] = 1'b0;
            addr = 16'(shadow_start[i]);
            return ST_OK;
        end
        return ST_NOFIT;
    endfunction

    // Release a block, then merge every adjacent free pair.
    function automatic logic [1:0] release_block(int addr);
        int k;
        int i;
        if (addr == 0)
            return ST_OK;
        k = lookup_used(addr);
        if (k < 0)
            return ST_UNKNOWN;
        shadow_free[k] = 1'b1;
        i = 0;
        while (i + 1 < shadow_count) begin
            if (shadow_free[i] && shadow_free[i+1]) begin
                shadow_size[i] += HEADER_BYTES + shadow_size[i+1];
                for (int j = i + 1; j + 1 < shadow_count; j++) begin
                    shadow_start[j] = shadow_start[j+1];
                    shadow_size[j]  = shadow_size[j+1];
                    shadow_free[j]  = shadow_free[j+1];
                end
                shadow_count--;
            end else begin
                i++;
            end
        end
        return ST_OK;
    endfunction

    // Work out the result of one request and update the shadow table.
    function automatic alloc_result_t predict_request(logic [1:0] fn, int req, int addr);
        alloc_result_t r;
        int            k;
        int            old_size;
        logic [1:0]    st;
        r = '0;
        if (fn == FN_INIT) begin
            shadow_start[0] = INIT_START;
            shadow_size[0]  = INIT_SIZE;
            shadow_free[0]  = 1'b1;
            shadow_count    = 1;
            shadow_ready    = 1'b1;
        end else if (!shadow_ready) begin
            r.status = ST_NOINIT;
        end else if (fn == FN_ALLOC || (fn == FN_REALLOC && addr == 0)) begin
            r.status = take_first_fit(req, r.address);
        end else if (fn == FN_FREE || req == 0) begin
            r.status = release_block(addr);
        end else begin
            k = lookup_used(addr);
            if (k < 0) begin
                r.status = ST_UNKNOWN;
            end else if (shadow_size[k] >= req) begin
                r.address = 16'(addr);
            end else begin
                old_size = shadow_size[k];
                st = take_first_fit(req, r.address);
                r.status = st;
                if (st == ST_OK) begin
                    r.copy_length = 16'(old_size);
                    void'(release_block(addr));
                end
            end
        end
        return r;
    endfunction

    // Predict on each accepted request, compare on each accepted result.
    always @(posedge aclk) begin
        alloc_result_t exp_r;
        alloc_result_t act_r;
        if (!aresetn) begin
            shadow_count    = 0;
            shadow_ready    = 1'b0;
            mismatch_count <= 0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                act_r.address     = m_tdata[15:0];
                act_r.copy_length = m_tdata[31:16];
                act_r.status      = m_tuser;
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%t: result with nothing expected: addr %0d st %0d copy %0d",
                                 $realtime, act_r.address, act_r.status, act_r.copy_length);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r != act_r) begin
                        if (mismatch_count < 10)
                            $display({"%t: mismatch: expected addr %0d st %0d copy %0d,",
                                      " got addr %0d st %0d copy %0d"}, $realtime,
                                     exp_r.address, exp_r.status, exp_r.copy_length,
                                     act_r.address, act_r.status, act_r.copy_length);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_request(s_tuser, s_tdata[15:0],
                                                           s_tdata[31:16]));
        end
        pending_count <= expected_results.size();
    end

endmodule

@@ test/tb_first_fit_heap_allocator_unit.sv @@
// ============================================================================
// First-fit heap allocator testbench
// Drives directed and random init, alloc, free and realloc requests with
// random gaps and stalls on both channels; a checker predicts and compares.
// ============================================================================
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator_unit;
    import fha_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    int          mismatch_count;
    int          pending_count;

    // Idle percentages of each side, and a long hold-off of the result side.
    int          send_idle_pct = 6;
    int          recv_idle_pct = 65;
    bit          hold_results  = 1'b0;
    logic [15:0] live_blocks[$];

    always #1 aclk = ~aclk;

    first_fit_heap_allocator_unit i_dut (.*);

    first_fit_heap_allocator_unit_checker i_checker (.*);

    // Result side: random stalls, and a counted hold-off when requested.
    always @(posedge aclk) begin
        if (hold_results) begin
            m_tready <= 1'b0;
            repeat (400) @(posedge aclk);
            hold_results = 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Remember addresses handed out so that frees and reallocs hit live blocks.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready && m_tuser == ST_OK && m_tdata[15:0] != 0)
            live_blocks.push_back(m_tdata[15:0]);
    end

    // Offer one request and wait until it is accepted.
    task automatic send_request(logic [1:0] fn, logic [15:0] req, logic [15:0] addr);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {addr, req};
        forever begin
            @(negedge aclk);
            if (s_tready) begin
                @(posedge aclk);
                break;
            end
        end
    endtask

    function automatic logic [15:0] pick_live();
        int k;
        if (live_blocks.size() == 0)
            return 16'($urandom_range(65535));
        k = $urandom_range(live_blocks.size() - 1);
        pick_live = live_blocks[k];
        live_blocks.delete(k);
    endfunction

    function automatic logic [15:0] random_size();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 16'($urandom_range(256));
        else if (r < 90)
            return 16'($urandom_range(4096));
        return 16'($urandom_range(65535));
    endfunction

    initial begin
        int r;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: use before init, then the corner cases of each operation.
        send_request(FN_ALLOC,   16'd16,    16'd0);
        send_request(FN_FREE,    16'd0,     16'd0);
        send_request(FN_FREE,    16'd0,     16'd8);
        send_request(FN_REALLOC, 16'd32,    16'd8);
        send_request(FN_INIT,    16'hFFFF,  16'hFFFF);
        send_request(FN_ALLOC,   16'hFFFF,  16'd0);
        send_request(FN_ALLOC,   INIT_SIZE, 16'd0);
        send_request(FN_FREE,    16'd0,     INIT_START);
        send_request(FN_FREE,    16'd0,     INIT_START);
        send_request(FN_INIT,    16'd0,     16'd0);
        send_request(FN_ALLOC,   16'd0,     16'd0);
        send_request(FN_ALLOC,   16'd24,    16'd0);
        send_request(FN_FREE,    16'd0,     16'd0);
        send_request(FN_REALLOC, 16'd40,    16'd0);
        send_request(FN_REALLOC, 16'd8,     16'd16);
        send_request(FN_REALLOC, 16'd100,   16'd16);
        send_request(FN_REALLOC, 16'hFFF0,  16'd24);
        send_request(FN_REALLOC, 16'd0,     16'd24);
        send_request(FN_REALLOC, 16'd10,    16'd12345);
        send_request(FN_FREE,    16'd0,     16'hFFFF);
        // Fill the table so later allocs take whole blocks.
        send_request(FN_INIT,    16'd0,     16'd0);
        for (int i = 0; i < 66; i++)
            send_request(FN_ALLOC, 16'd100, 16'd0);
        send_request(FN_ALLOC, 16'd0, 16'd0);

        // Pause until everything is answered, then start the random part.
        // Wait for the clock first so that the pending count includes the last request.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending_count == 0);
        @(posedge aclk);
        live_blocks.delete();
        send_request(FN_INIT, 16'd0, 16'd0);

        for (int n = 0; n < 1000; n++) begin
            if (n == 333) begin
                send_idle_pct = 65;
                recv_idle_pct = 6;
            end else if (n == 666) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n == 200 || n == 800)
                hold_results = 1'b1;
            r = $urandom_range(99);
            if (r < 40)
                send_request(FN_ALLOC, random_size(), 16'($urandom_range(65535)));
            else if (r < 68)
                send_request(FN_FREE, 16'($urandom_range(65535)), pick_live());
            else if (r < 84)
                send_request(FN_REALLOC, random_size(), pick_live());
            else if (r < 86)
                send_request(FN_REALLOC, 16'd0, pick_live());
            else if (r < 88) begin
                send_request(FN_INIT, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
                live_blocks.delete();
            end else
                send_request(2'($urandom_range(3)), 16'($urandom_range(65535)),
                             16'($urandom_range(65535)));
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        wait (pending_count == 0);
        repeat (1000) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("tb_first_fit_heap_allocator_unit: clean");
        else
            $display("tb_first_fit_heap_allocator_unit: errors");
        $finish;
    end

    // Hard limit on the run.
    initial begin
        #20000000;
        $display("tb_first_fit_heap_allocator_unit: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/fha_pkg.sv
hdl/fha_alu.sv
hdl/fha_table.sv
hdl/fha_seq.sv
hdl/first_fit_heap_allocator_unit.sv
hdl/fha_checker.sv
test/first_fit_heap_allocator_unit_checker.sv
test/tb_first_fit_heap_allocator_unit.sv
